/* hdl/spc_pkg.sv */
// Shared types, codes and constants of the sprite pixel collision unit.
package spc_pkg;

    localparam int MAX_DIM_DEFAULT = 32;

    localparam int REQ_W       = 2;
    localparam int INDEX_W     = 10;
    localparam int CHAR_W      = 8;
    localparam int COORD_W     = 10;
    localparam int SIZE_W      = 6;
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 8;

    localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'd32;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD_A = 2'd0,
        REQ_LOAD_B = 2'd1,
        REQ_CHECK  = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic wr_a;
        logic wr_b;
        logic start;
        logic step;
        logic out_load;
    } spc_cmd_t;

    typedef struct packed {
        logic zero_size;
        logic last_cell;
        logic pipe_busy;
    } spc_status_t;

endpackage

/* hdl/spc_ctrl.sv */
// Controller state machine of the sprite pixel collision unit.
module spc_ctrl
    import spc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [REQ_W-1:0] in_req,
    output logic          out_valid,
    input  logic          out_ready,
    output spc_cmd_t      cmd,
    input  spc_status_t   status
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    req_t   req;

    assign req       = req_t'(in_req);
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (req)
                        REQ_LOAD_A: cmd.wr_a = 1'b1;
                        REQ_LOAD_B: cmd.wr_b = 1'b1;
                        REQ_CHECK:
                        begin
                            cmd.start  = 1'b1;
                            state_next = status.zero_size ? ST_RESULT : ST_SCAN;
                        end
                        REQ_NONE: cmd = '0;
                    endcase
                end
            end
            ST_SCAN:
            begin
                cmd.step = 1'b1;
                if (status.last_cell)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

endmodule

/* hdl/spc_datapath.sv */
// Datapath: bitmap stores, scan counters, address pipeline and result register.
module spc_datapath
    import spc_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  spc_cmd_t                  cmd,
    output spc_status_t               status,
    input  logic [INDEX_W-1:0]        pixel_index,
    input  logic [CHAR_W-1:0]         pixel_char,
    input  logic signed [COORD_W-1:0] ax,
    input  logic signed [COORD_W-1:0] ay,
    input  logic [SIZE_W-1:0]         aw,
    input  logic [SIZE_W-1:0]         ah,
    input  logic signed [COORD_W-1:0] bx,
    input  logic signed [COORD_W-1:0] by_top,
    input  logic [SIZE_W-1:0]         bw,
    input  logic [SIZE_W-1:0]         bh,
    output logic                      collided
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int CW    = ((DIM_W > COORD_W) ? DIM_W : COORD_W) + 2;

    logic mem_a [DEPTH];
    logic mem_b [DEPTH];

    logic signed [COORD_W-1:0] ax_reg, ay_reg, bx_reg, by_reg;
    logic [DIM_W-1:0] aw_reg, ah_reg, bw_reg, bh_reg;
    logic [DIM_W-1:0] aw_c, ah_c, bw_c, bh_c;
    logic [DIM_W-1:0] i_reg, j_reg;
    logic [AW-1:0]    ia_reg;

    logic [CW-1:0]      bi, bj;
    logic [DIM_W-1:0]   bi_t, bj_t;
    logic [2*DIM_W-1:0] ib_wide;
    logic               in_b;
    logic               row_end;

    logic          p1_valid_reg, p2_valid_reg;
    logic [AW-1:0] p1_ia_reg, p1_ib_reg;
    logic          rd_a_reg, rd_b_reg;
    logic          hit_reg, hit_next;
    logic          collided_reg;

    logic          load_ok;
    logic [AW-1:0] load_addr;
    logic          opaque;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [SIZE_W-1:0] d);
        if (32'(d) > MAX_DIM)
        begin
            return DIM_W'(MAX_DIM);
        end
        return DIM_W'(d);
    endfunction

    assign aw_c = clamp_dim(aw);
    assign ah_c = clamp_dim(ah);
    assign bw_c = clamp_dim(bw);
    assign bh_c = clamp_dim(bh);

    assign status.zero_size = (aw == '0) || (ah == '0) || (bw == '0) || (bh == '0);
    assign row_end          = (i_reg == aw_reg - DIM_W'(1));
    assign status.last_cell = row_end && (j_reg == ah_reg - DIM_W'(1));
    assign status.pipe_busy = p1_valid_reg || p2_valid_reg;

    // Position of the current sprite A cell within sprite B's bitmap.
    assign bi   = CW'(ax_reg) + CW'(i_reg) - CW'(bx_reg);
    assign bj   = CW'(ay_reg) + CW'(j_reg) - CW'(by_reg);
    assign in_b = !bi[CW-1] && (bi < CW'(bw_reg)) && !bj[CW-1] && (bj < CW'(bh_reg));
    assign bi_t = bi[DIM_W-1:0];
    assign bj_t = bj[DIM_W-1:0];
    assign ib_wide = (2*DIM_W)'(bi_t) + bj_t * bw_reg;

    assign opaque    = (pixel_char != SPACE_CHAR);
    assign load_ok   = (32'(pixel_index) < DEPTH);
    assign load_addr = AW'(pixel_index);

    assign hit_next = hit_reg || (p2_valid_reg && rd_a_reg && rd_b_reg);
    assign collided = collided_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_a && load_ok)
        begin
            mem_a[load_addr] <= opaque;
        end
        if (cmd.wr_b && load_ok)
        begin
            mem_b[load_addr] <= opaque;
        end
        rd_a_reg <= mem_a[p1_ia_reg];
        rd_b_reg <= mem_b[p1_ib_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            hit_reg      <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= cmd.step && in_b;
            p2_valid_reg <= p1_valid_reg;
            hit_reg      <= cmd.start ? 1'b0 : hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_ia_reg <= ia_reg;
        p1_ib_reg <= AW'(ib_wide);
        if (cmd.out_load)
        begin
            collided_reg <= hit_reg;
        end
        if (cmd.start)
        begin
            ax_reg <= ax;
            ay_reg <= ay;
            bx_reg <= bx;
            by_reg <= by_top;
            aw_reg <= aw_c;
            ah_reg <= ah_c;
            bw_reg <= bw_c;
            bh_reg <= bh_c;
            i_reg  <= '0;
            j_reg  <= '0;
            ia_reg <= '0;
        end
        else if (cmd.step)
        begin
            ia_reg <= ia_reg + AW'(1);
            if (row_end)
            begin
                i_reg <= '0;
                j_reg <= j_reg + DIM_W'(1);
            end
            else
            begin
                i_reg <= i_reg + DIM_W'(1);
            end
        end
    end

endmodule

/* hdl/sprite_pixel_collision_unit.sv */
// Top level of the sprite pixel collision unit: stream ports, controller and datapath.
// A load item is accepted back to back and gives no result.
// A check item scans sprite A one cell per cycle (sizes saturated to MAX_DIM), then
// drains the address and store read pipeline and loads the result register, which waits
// while a previous result is still held; the next item is taken once the result is loaded.
// A check with a zero size skips the scan and goes straight to loading the result.
// The asynchronous active-low reset returns the controller to idle and empties the output;
// the bitmap stores are not cleared and hold no defined content until loaded.
module sprite_pixel_collision_unit
    import spc_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEFAULT
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // From bit 0 up: pixel_index[10], pixel_char[8], ax[10], ay[10], aw[6], ah[6],
    // bx[10], by_top[10], bw[6], bh[6], zero fill.
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // From bit 0 up: req_type[2].
    input  logic [REQ_W-1:0]       s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // From bit 0 up: collided[1], zero fill.
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    spc_cmd_t    cmd;
    spc_status_t status;
    logic        collided;

    // The controller accepts an item only while idle; the result sits in its own output
    // register, so loads can go on while a finished check result waits to be taken.
    spc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_req    (s_axis_tuser),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .status    (status)
    );

    // The item fields are sliced directly from the stream word at the datapath ports.
    spc_datapath #(
        .MAX_DIM (MAX_DIM)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .pixel_index (s_axis_tdata[9:0]),
        .pixel_char  (s_axis_tdata[17:10]),
        .ax          (s_axis_tdata[27:18]),
        .ay          (s_axis_tdata[37:28]),
        .aw          (s_axis_tdata[43:38]),
        .ah          (s_axis_tdata[49:44]),
        .bx          (s_axis_tdata[59:50]),
        .by_top      (s_axis_tdata[69:60]),
        .bw          (s_axis_tdata[75:70]),
        .bh          (s_axis_tdata[81:76]),
        .collided    (collided)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W-1){1'b0}}, collided};

endmodule
